/* rtl/pl0tok_pkg.sv */
package pl0tok_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [2:0]  error_code;
    logic [15:0] start_pos;
    logic [7:0]  token_length;
    logic [30:0] int_value;
    logic        last_of_run;
  } out_word_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_KEYWORD,
    MODE_NUMBER,
    MODE_LESS,
    MODE_GREATER,
    MODE_COLON,
    MODE_SKIP
  } scan_mode_t;

  typedef enum logic [3:0] {
    CC_SPACE,
    CC_LOWER,
    CC_UPPER,
    CC_DIGIT,
    CC_LESS,
    CC_GREATER,
    CC_COLON,
    CC_EQUAL,
    CC_SINGLE,
    CC_ILLEGAL
  } char_class_t;

  typedef struct packed {
    logic [7:0]  char_byte;
    logic        last_char;
    char_class_t cclass;
    logic [4:0]  single_kind;
  } cls_word_t;

  typedef struct packed {
    logic      vld0;
    logic      vld1;
    out_word_t w0;
    out_word_t w1;
  } res_pair_t;

  typedef struct packed {
    logic      vld;
    logic      skip;
    out_word_t word;
  } fin_t;

  localparam logic [4:0] KIND_ERR    = 5'd0;
  localparam logic [4:0] KIND_IDENT  = 5'd10;
  localparam logic [4:0] KIND_INT    = 5'd11;
  localparam logic [4:0] KIND_PLUS   = 5'd12;
  localparam logic [4:0] KIND_MINUS  = 5'd13;
  localparam logic [4:0] KIND_TIMES  = 5'd14;
  localparam logic [4:0] KIND_SLASH  = 5'd15;
  localparam logic [4:0] KIND_ASSIGN = 5'd16;
  localparam logic [4:0] KIND_EQUAL  = 5'd17;
  localparam logic [4:0] KIND_NOTEQ  = 5'd18;
  localparam logic [4:0] KIND_GT     = 5'd19;
  localparam logic [4:0] KIND_GE     = 5'd20;
  localparam logic [4:0] KIND_LT     = 5'd21;
  localparam logic [4:0] KIND_LE     = 5'd22;
  localparam logic [4:0] KIND_LPAREN = 5'd23;
  localparam logic [4:0] KIND_RPAREN = 5'd24;
  localparam logic [4:0] KIND_SEMI   = 5'd25;
  localparam logic [4:0] KIND_COMMA  = 5'd26;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_KEYWORD  = 3'd1;
  localparam logic [2:0] ERR_COLON    = 3'd2;
  localparam logic [2:0] ERR_ILLEGAL  = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

  localparam int KW_COUNT = 9;
  localparam int KW_MAX   = 7;

  localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
    "PROGRAM",
    {"BEGIN", 16'h0000},
    {"END", 32'h0000_0000},
    {"CONST", 16'h0000},
    {"VAR", 32'h0000_0000},
    {"WHILE", 16'h0000},
    {"DO", 40'h00_0000_0000},
    {"IF", 40'h00_0000_0000},
    {"THEN", 24'h00_0000}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd7, 3'd5, 3'd3, 3'd5, 3'd3, 3'd5, 3'd2, 3'd2, 3'd4
  };

  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = 1;
  localparam int CQ_CW    = 2;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  function automatic logic [4:0] keyword_kind(input logic [8*KW_MAX-1:0] word,
                                              input logic [7:0] len);
    logic [4:0] kind;
    logic       hit;
    kind = KIND_ERR;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      hit = (len == 8'(KW_LEN[i]));
      for (int k = 0; k < KW_MAX; k++) begin
        if (k < int'(KW_LEN[i]) &&
            word[8*(KW_MAX-1-k) +: 8] != KW_TEXT[i][8*(KW_MAX-1-k) +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kind = 5'(i + 1);
      end
    end
    return kind;
  endfunction

  function automatic fin_t finish_token(input scan_mode_t mode, input logic [15:0] start,
                                        input logic [7:0] len, input logic [30:0] acc,
                                        input logic ovf, input logic [4:0] kw);
    fin_t f;
    f.vld               = 1'b1;
    f.skip              = 1'b0;
    f.word.token_kind   = KIND_ERR;
    f.word.error_code   = ERR_NONE;
    f.word.start_pos    = start;
    f.word.token_length = len;
    f.word.int_value    = '0;
    f.word.last_of_run  = 1'b0;
    unique case (mode)
      MODE_IDENT: begin
        f.word.token_kind = KIND_IDENT;
      end
      MODE_KEYWORD: begin
        if (kw == KIND_ERR) begin
          f.word.error_code = ERR_KEYWORD;
          f.skip            = 1'b1;
        end else begin
          f.word.token_kind = kw;
        end
      end
      MODE_NUMBER: begin
        f.word.token_kind = KIND_INT;
        f.word.error_code = ovf ? ERR_OVERFLOW : ERR_NONE;
        f.word.int_value  = acc;
      end
      MODE_LESS: begin
        f.word.token_kind   = KIND_LT;
        f.word.token_length = 8'd1;
      end
      MODE_GREATER: begin
        f.word.token_kind   = KIND_GT;
        f.word.token_length = 8'd1;
      end
      MODE_COLON: begin
        f.word.error_code   = ERR_COLON;
        f.word.token_length = 8'd1;
        f.skip              = 1'b1;
      end
      default: begin
        f.vld = 1'b0;
      end
    endcase
    return f;
  endfunction

endpackage

/* rtl/pl0_source_tokenizer.sv */
// Channel   Ports                       Handshake
// input     push, full, in_word         taken when push && !full
// result    empty, pop, out_word        taken when pop && !empty
//
// One character per cycle unless held: the classifier queue and scanner move one word
// a cycle, the token queue takes both tokens of a character at once, and they leave as
// two pops. The scanner holds while fewer than two of the four token entries are free,
// and push sees full once the two-entry character queue fills behind it.
// A token is written into the token queue by the edge that accepts its ending character.
// Synchronous reset clears the queues and the scanner; no clearing pass.
module pl0_source_tokenizer #(
  parameter int KEYWORD_CHARS = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  pl0tok_pkg::in_word_t  in_word,
  output logic                  empty,
  input  logic                  pop,
  output pl0tok_pkg::out_word_t out_word
);
  import pl0tok_pkg::*;

  logic      cls_vld;
  cls_word_t cls_word;
  logic      cls_pop;
  logic      oq_room;
  res_pair_t res;

  pl0tok_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .cls_vld  (cls_vld),
    .cls_word (cls_word),
    .cls_pop  (cls_pop)
  );

  pl0tok_scan #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cls_vld  (cls_vld),
    .cls_word (cls_word),
    .cls_pop  (cls_pop),
    .oq_room  (oq_room),
    .res      (res)
  );

  pl0tok_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .oq_room  (oq_room),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule

/* rtl/pl0tok_front.sv */
module pl0tok_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  pl0tok_pkg::in_word_t  in_word,
  output logic                  cls_vld,
  output pl0tok_pkg::cls_word_t cls_word,
  input  logic                  cls_pop
);
  import pl0tok_pkg::*;

  cls_word_t        cw;
  logic [7:0]       c;
  cls_word_t        ent_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_r, wr_nxt;
  logic [CQ_AW-1:0] rd_r, rd_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;
  logic             wr_en;
  logic             rd_en;

  assign c = in_word.char_byte;

  always_comb begin
    cw.char_byte   = in_word.char_byte;
    cw.last_char   = in_word.last_char;
    cw.single_kind = KIND_ERR;
    cw.cclass      = CC_ILLEGAL;
    priority if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
      cw.cclass = CC_SPACE;
    end else if (c >= "a" && c <= "z") begin
      cw.cclass = CC_LOWER;
    end else if (c >= "A" && c <= "Z") begin
      cw.cclass = CC_UPPER;
    end else if (c >= "0" && c <= "9") begin
      cw.cclass = CC_DIGIT;
    end else if (c == "<") begin
      cw.cclass = CC_LESS;
    end else if (c == ">") begin
      cw.cclass = CC_GREATER;
    end else if (c == ":") begin
      cw.cclass = CC_COLON;
    end else if (c == "=") begin
      cw.cclass      = CC_EQUAL;
      cw.single_kind = KIND_EQUAL;
    end else begin
      unique case (c)
        "+": begin cw.cclass = CC_SINGLE; cw.single_kind = KIND_PLUS;   end
        "-": begin cw.cclass = CC_SINGLE; cw.single_kind = KIND_MINUS;  end
        "*": begin cw.cclass = CC_SINGLE; cw.single_kind = KIND_TIMES;  end
        "/": begin cw.cclass = CC_SINGLE; cw.single_kind = KIND_SLASH;  end
        "(": begin cw.cclass = CC_SINGLE; cw.single_kind = KIND_LPAREN; end
        ")": begin cw.cclass = CC_SINGLE; cw.single_kind = KIND_RPAREN; end
        ";": begin cw.cclass = CC_SINGLE; cw.single_kind = KIND_SEMI;   end
        ",": begin cw.cclass = CC_SINGLE; cw.single_kind = KIND_COMMA;  end
        default: begin
          cw.cclass = CC_ILLEGAL;
        end
      endcase
    end
  end

  assign full     = (cnt_r == CQ_CW'(CQ_DEPTH));
  assign wr_en    = push && !full;
  assign cls_vld  = (cnt_r != '0);
  assign rd_en    = cls_pop && cls_vld;
  assign cls_word = ent_r[rd_r];

  always_comb begin
    wr_nxt  = wr_en ? wr_r + CQ_AW'(1) : wr_r;
    rd_nxt  = rd_en ? rd_r + CQ_AW'(1) : rd_r;
    cnt_nxt = cnt_r + CQ_CW'(wr_en) - CQ_CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r[wr_r] <= cw;
    end
  end

endmodule

/* rtl/pl0tok_scan.sv */
module pl0tok_scan #(
  parameter int KEYWORD_CHARS = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cls_vld,
  input  pl0tok_pkg::cls_word_t cls_word,
  output logic                  cls_pop,
  input  logic                  oq_room,
  output pl0tok_pkg::res_pair_t res
);
  import pl0tok_pkg::*;

  localparam int IW = $clog2(KEYWORD_CHARS);

  scan_mode_t             mode_r, mode_s, mode_nxt;
  logic [15:0]            start_r, start_s, start_nxt;
  logic [7:0]             len_r, len_s, len_nxt;
  logic [30:0]            acc_r, acc_s, acc_nxt;
  logic                   ovf_r, ovf_s, ovf_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]             buf_r [KEYWORD_CHARS];
  logic [7:0]             buf_nxt [KEYWORD_CHARS];

  logic [31:0]            pos_ext;
  logic [15:0]            pos16;
  logic                   go;
  logic                   handled;
  logic                   last;
  logic [7:0]             c;
  char_class_t            cc;
  logic [34:0]            acc_sum;
  logic                   acc_sat;
  logic [7:0]             len_inc;
  logic [IW-1:0]          wr_idx;
  logic [8*KW_MAX-1:0]    word_cur, word_nxt;
  logic [4:0]             kw_cur, kw_nxt;
  fin_t                   fin1, fin2;
  out_word_t              ea, eb, b_word;
  logic                   ea_vld, eb_vld, b_vld;

  assign c       = cls_word.char_byte;
  assign cc      = cls_word.cclass;
  assign last    = cls_word.last_char;
  assign go      = cls_vld && oq_room;
  assign cls_pop = go;
  assign pos_ext = 32'(pos_r);
  assign pos16   = pos_ext[15:0];
  assign wr_idx  = len_r[IW-1:0];
  assign len_inc = (len_r == 8'hFF) ? len_r : len_r + 8'd1;
  assign acc_sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {31'd0, c[3:0]};
  assign acc_sat = (acc_sum > {4'd0, INT_MAX});

  always_comb begin
    for (int k = 0; k < KW_MAX; k++) begin
      word_cur[8*(KW_MAX-1-k) +: 8] = buf_r[k];
      word_nxt[8*(KW_MAX-1-k) +: 8] = buf_nxt[k];
    end
    kw_cur = keyword_kind(word_cur, len_r);
    kw_nxt = keyword_kind(word_nxt, len_s);
  end

  always_comb begin
    mode_s  = mode_r;
    start_s = start_r;
    len_s   = len_r;
    acc_s   = acc_r;
    ovf_s   = ovf_r;
    buf_nxt = buf_r;
    handled = 1'b0;
    ea_vld  = 1'b0;
    eb_vld  = 1'b0;
    fin1    = finish_token(mode_r, start_r, len_r, acc_r, ovf_r, kw_cur);
    ea      = fin1.word;
    eb              = '0;
    eb.start_pos    = pos16;
    eb.token_length = 8'd1;
    ea.token_length = fin1.word.token_length;

    unique case (mode_r)
      MODE_SKIP: begin
        handled = 1'b1;
      end
      MODE_IDENT: begin
        if (cc == CC_LOWER || cc == CC_DIGIT) begin
          handled = 1'b1;
          len_s   = len_inc;
        end
      end
      MODE_KEYWORD: begin
        if (cc == CC_UPPER || cc == CC_DIGIT) begin
          handled = 1'b1;
          len_s   = len_inc;
          if (len_r < 8'(KEYWORD_CHARS)) begin
            buf_nxt[wr_idx] = c;
          end
        end
      end
      MODE_NUMBER: begin
        if (cc == CC_DIGIT) begin
          handled = 1'b1;
          len_s   = len_inc;
          acc_s   = acc_sat ? INT_MAX : acc_sum[30:0];
          ovf_s   = ovf_r | acc_sat;
        end
      end
      MODE_LESS: begin
        if (cc == CC_EQUAL || cc == CC_GREATER) begin
          handled          = 1'b1;
          ea_vld           = 1'b1;
          ea               = '0;
          ea.token_kind    = (cc == CC_EQUAL) ? KIND_LE : KIND_NOTEQ;
          ea.start_pos     = start_r;
          ea.token_length  = 8'd2;
          mode_s           = MODE_IDLE;
        end
      end
      MODE_GREATER: begin
        if (cc == CC_EQUAL) begin
          handled          = 1'b1;
          ea_vld           = 1'b1;
          ea               = '0;
          ea.token_kind    = KIND_GE;
          ea.start_pos     = start_r;
          ea.token_length  = 8'd2;
          mode_s           = MODE_IDLE;
        end
      end
      MODE_COLON: begin
        if (cc == CC_EQUAL) begin
          handled          = 1'b1;
          ea_vld           = 1'b1;
          ea               = '0;
          ea.token_kind    = KIND_ASSIGN;
          ea.start_pos     = start_r;
          ea.token_length  = 8'd2;
          mode_s           = MODE_IDLE;
        end
      end
      default: begin
      end
    endcase

    if (!handled) begin
      mode_s = MODE_IDLE;
      if (fin1.vld) begin
        ea_vld = 1'b1;
        if (fin1.skip) begin
          mode_s = MODE_SKIP;
        end
      end
      if (mode_s == MODE_IDLE) begin
        unique case (cc)
          CC_SPACE: begin
          end
          CC_LOWER: begin
            mode_s  = MODE_IDENT;
            start_s = pos16;
            len_s   = 8'd1;
          end
          CC_UPPER: begin
            mode_s     = MODE_KEYWORD;
            start_s    = pos16;
            len_s      = 8'd1;
            buf_nxt[0] = c;
          end
          CC_DIGIT: begin
            mode_s  = MODE_NUMBER;
            start_s = pos16;
            len_s   = 8'd1;
            acc_s   = 31'(c[3:0]);
            ovf_s   = 1'b0;
          end
          CC_LESS: begin
            mode_s  = MODE_LESS;
            start_s = pos16;
            len_s   = 8'd1;
          end
          CC_GREATER: begin
            mode_s  = MODE_GREATER;
            start_s = pos16;
            len_s   = 8'd1;
          end
          CC_COLON: begin
            mode_s  = MODE_COLON;
            start_s = pos16;
            len_s   = 8'd1;
          end
          CC_EQUAL, CC_SINGLE: begin
            eb_vld        = 1'b1;
            eb.token_kind = cls_word.single_kind;
          end
          default: begin
            eb_vld        = 1'b1;
            eb.token_kind = KIND_ERR;
            eb.error_code = ERR_ILLEGAL;
            mode_s        = MODE_SKIP;
          end
        endcase
      end
    end
  end

  always_comb begin
    fin2   = finish_token(mode_s, start_s, len_s, acc_s, ovf_s, kw_nxt);
    b_vld  = eb_vld || (last && fin2.vld);
    b_word = eb_vld ? eb : fin2.word;

    if (ea_vld) begin
      res.vld0 = go;
      res.vld1 = go && b_vld;
      res.w0   = ea;
      res.w1   = b_word;
    end else begin
      res.vld0 = go && b_vld;
      res.vld1 = 1'b0;
      res.w0   = b_word;
      res.w1   = b_word;
    end
    res.w0.last_of_run = !(ea_vld && b_vld);
    res.w1.last_of_run = 1'b1;

    if (last) begin
      mode_nxt  = MODE_IDLE;
      start_nxt = '0;
      len_nxt   = '0;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      pos_nxt   = '0;
    end else begin
      mode_nxt  = mode_s;
      start_nxt = start_s;
      len_nxt   = len_s;
      acc_nxt   = acc_s;
      ovf_nxt   = ovf_s;
      pos_nxt   = pos_r + POSITION_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      len_r   <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      pos_r   <= '0;
    end else if (go) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      buf_r <= buf_nxt;
    end
  end

endmodule

/* rtl/pl0tok_outq.sv */
module pl0tok_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pl0tok_pkg::res_pair_t res,
  output logic                  oq_room,
  output logic                  empty,
  input  logic                  pop,
  output pl0tok_pkg::out_word_t out_word
);
  import pl0tok_pkg::*;

  out_word_t        ent_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_r, wr_nxt;
  logic [OQ_AW-1:0] rd_r, rd_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic [OQ_CW-1:0] n_wr;
  logic             rd_en;

  assign empty    = (cnt_r == '0);
  assign oq_room  = (cnt_r <= OQ_CW'(OQ_DEPTH - 2));
  assign rd_en    = pop && !empty;
  assign out_word = ent_r[rd_r];
  assign n_wr     = OQ_CW'(res.vld0) + OQ_CW'(res.vld1);

  always_comb begin
    wr_nxt  = wr_r + n_wr[OQ_AW-1:0];
    rd_nxt  = rd_en ? rd_r + OQ_AW'(1) : rd_r;
    cnt_nxt = cnt_r + n_wr - OQ_CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld0) begin
      ent_r[wr_r] <= res.w0;
    end
    if (res.vld1) begin
      ent_r[wr_r + OQ_AW'(1)] <= res.w1;
    end
  end

endmodule
